// ===== design/cscr_pkg.sv =====
// Shared types, constants and saturation helpers for the circle/square collision block.
package cscr_pkg;

   localparam int POS_W       = 21;
   localparam int HEAD_W      = 16;
   localparam int RAD_W       = 16;
   localparam int SIDE_W      = 18;
   localparam int CRD_W       = 24;
   localparam int DLT_W       = 17;
   localparam int D2_W        = 32;
   localparam int UNIT_BITS   = 14;
   localparam int NORM_BITS   = 28;
   localparam int SQ_STAGES   = 30;
   localparam int QUO_W       = 17;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int CSR_IDX_W   = 2;

   typedef enum logic [3:0] {
      CT_NONE   = 4'd0,
      CT_LEFT   = 4'd1,
      CT_RIGHT  = 4'd2,
      CT_TOP    = 4'd3,
      CT_BOTTOM = 4'd4,
      CT_TL     = 4'd5,
      CT_TR     = 4'd6,
      CT_BL     = 4'd7,
      CT_BR     = 4'd8
   } contact_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RADIUS = 2'd0,
      CSR_SIDE   = 2'd1
   } csr_index_type;

   typedef struct packed {
      contact_type              contact;
      logic                     arith;
      logic signed [CRD_W-1:0]  cx;
      logic signed [CRD_W-1:0]  cy;
      logic signed [DLT_W-1:0]  dx;
      logic signed [DLT_W-1:0]  dy;
      logic [D2_W-1:0]          d2;
      logic signed [HEAD_W-1:0] hx;
      logic signed [HEAD_W-1:0] hy;
      logic [RAD_W-1:0]         r;
      logic signed [POS_W-1:0]  px;
      logic signed [POS_W-1:0]  py;
      logic signed [HEAD_W-1:0] phx;
      logic signed [HEAD_W-1:0] phy;
   } job_type;

   function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [31:0] v);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = (32'sd1 <<< (POS_W - 1)) - 32'sd1;
      lo = -hi - 32'sd1;
      if (v > hi) sat_pos = hi[POS_W-1:0];
      else if (v < lo) sat_pos = lo[POS_W-1:0];
      else sat_pos = v[POS_W-1:0];
   endfunction

   function automatic logic signed [HEAD_W-1:0] sat_head(input logic signed [31:0] v);
      logic signed [31:0] hi;
      logic signed [31:0] lo;
      hi = (32'sd1 <<< (HEAD_W - 1)) - 32'sd1;
      lo = -hi - 32'sd1;
      if (v > hi) sat_head = hi[HEAD_W-1:0];
      else if (v < lo) sat_head = lo[HEAD_W-1:0];
      else sat_head = v[HEAD_W-1:0];
   endfunction

endpackage

// ===== design/cscr_front.sv =====
// Front end: side tests, corner distance squares and contact selection.
module cscr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [cscr_pkg::POS_W-1:0]  req_circle_x,
   input  logic signed [cscr_pkg::POS_W-1:0]  req_circle_y,
   input  logic signed [cscr_pkg::HEAD_W-1:0] req_heading_x,
   input  logic signed [cscr_pkg::HEAD_W-1:0] req_heading_y,
   input  logic signed [cscr_pkg::POS_W-1:0]  req_square_left,
   input  logic signed [cscr_pkg::POS_W-1:0]  req_square_top,
   input  logic [cscr_pkg::RAD_W-1:0]         cfg_radius,
   input  logic [cscr_pkg::SIDE_W-1:0]        cfg_side,
   output logic                              push_valid,
   output cscr_pkg::job_type                 push_job,
   input  logic                              push_full
);
   import cscr_pkg::*;

   typedef struct packed {
      contact_type                 side_ct;
      logic signed [POS_W-1:0]     spx;
      logic signed [POS_W-1:0]     spy;
      logic signed [HEAD_W-1:0]    sphx;
      logic signed [HEAD_W-1:0]    sphy;
      logic [3:0]                  near;
      logic [3:0][DLT_W-1:0]       dx;
      logic [3:0][DLT_W-1:0]       dy;
      logic signed [CRD_W-1:0]     left;
      logic signed [CRD_W-1:0]     right;
      logic signed [CRD_W-1:0]     top;
      logic signed [CRD_W-1:0]     bottom;
      logic signed [HEAD_W-1:0]    hx;
      logic signed [HEAD_W-1:0]    hy;
      logic [RAD_W-1:0]            r;
   } s1_type;

   typedef struct packed {
      s1_type                b;
      logic [3:0][D2_W:0]    sq;
      logic [D2_W-1:0]       rr;
   } s2_type;

   s1_type s1_in, s1_ff;
   s2_type s2_in, s2_ff;
   logic   s1_v_ff, s2_v_ff;
   logic   adv;

   assign adv        = !s2_v_ff || !push_full;
   assign req_ready  = adv;
   assign push_valid = s2_v_ff && !push_full;

   always_comb begin
      logic signed [CRD_W-1:0] x, y, r, sd, dxw, dyw;
      logic signed [CRD_W-1:0] cxk, cyk;
      logic                    yspan, xspan;
      x  = CRD_W'(req_circle_x);
      y  = CRD_W'(req_circle_y);
      r  = $signed({{(CRD_W-RAD_W){1'b0}}, cfg_radius});
      sd = $signed({{(CRD_W-SIDE_W){1'b0}}, cfg_side});
      s1_in        = '0;
      s1_in.left   = CRD_W'(req_square_left);
      s1_in.top    = CRD_W'(req_square_top);
      s1_in.right  = s1_in.left + sd;
      s1_in.bottom = s1_in.top + sd;
      s1_in.hx     = req_heading_x;
      s1_in.hy     = req_heading_y;
      s1_in.r      = cfg_radius;
      s1_in.spx    = req_circle_x;
      s1_in.spy    = req_circle_y;
      s1_in.sphx   = req_heading_x;
      s1_in.sphy   = req_heading_y;
      s1_in.side_ct = CT_NONE;
      yspan = (y + r >= s1_in.top) && (y - r <= s1_in.bottom);
      xspan = (x + r >= s1_in.left) && (x - r <= s1_in.right);
      if (x + r >= s1_in.left && x < s1_in.left && yspan) begin
         s1_in.side_ct = CT_LEFT;
         s1_in.spx     = sat_pos(32'(s1_in.left - r));
         s1_in.sphx    = sat_head(-32'(req_heading_x));
      end else if (x - r <= s1_in.right && x > s1_in.right && yspan) begin
         s1_in.side_ct = CT_RIGHT;
         s1_in.spx     = sat_pos(32'(s1_in.right + r));
         s1_in.sphx    = sat_head(-32'(req_heading_x));
      end else if (y + r >= s1_in.top && y < s1_in.top && xspan) begin
         s1_in.side_ct = CT_TOP;
         s1_in.spy     = sat_pos(32'(s1_in.top - r));
         s1_in.sphy    = sat_head(-32'(req_heading_y));
      end else if (y - r <= s1_in.bottom && y > s1_in.bottom && xspan) begin
         s1_in.side_ct = CT_BOTTOM;
         s1_in.spy     = sat_pos(32'(s1_in.bottom + r));
         s1_in.sphy    = sat_head(-32'(req_heading_y));
      end
      for (int k = 0; k < 4; k++) begin
         cxk = k[0] ? s1_in.right : s1_in.left;
         cyk = k[1] ? s1_in.bottom : s1_in.top;
         dxw = x - cxk;
         dyw = y - cyk;
         s1_in.near[k] = (dxw <= r) && (dxw >= -r) && (dyw <= r) && (dyw >= -r);
         s1_in.dx[k]   = dxw[DLT_W-1:0];
         s1_in.dy[k]   = dyw[DLT_W-1:0];
      end
   end

   always_comb begin
      logic signed [2*DLT_W-1:0] px2, py2;
      s2_in.b = s1_ff;
      for (int k = 0; k < 4; k++) begin
         px2 = $signed(s1_ff.dx[k]) * $signed(s1_ff.dx[k]);
         py2 = $signed(s1_ff.dy[k]) * $signed(s1_ff.dy[k]);
         s2_in.sq[k] = {1'b0, px2[D2_W-1:0]} + {1'b0, py2[D2_W-1:0]};
      end
      s2_in.rr = D2_W'(s1_ff.r * s1_ff.r);
   end

   always_comb begin
      logic [1:0] sel;
      logic       found;
      sel   = 2'd0;
      found = 1'b0;
      for (int k = 3; k >= 0; k--) begin
         if (s2_ff.b.near[k] && s2_ff.sq[k] <= {1'b0, s2_ff.rr}) begin
            sel   = 2'(k);
            found = 1'b1;
         end
      end
      push_job.cx    = sel[0] ? s2_ff.b.right : s2_ff.b.left;
      push_job.cy    = sel[1] ? s2_ff.b.bottom : s2_ff.b.top;
      push_job.dx    = $signed(s2_ff.b.dx[sel]);
      push_job.dy    = $signed(s2_ff.b.dy[sel]);
      push_job.d2    = s2_ff.sq[sel][D2_W-1:0];
      push_job.hx    = s2_ff.b.hx;
      push_job.hy    = s2_ff.b.hy;
      push_job.r     = s2_ff.b.r;
      push_job.px    = s2_ff.b.spx;
      push_job.py    = s2_ff.b.spy;
      push_job.phx   = s2_ff.b.sphx;
      push_job.phy   = s2_ff.b.sphy;
      push_job.arith = 1'b0;
      push_job.contact = s2_ff.b.side_ct;
      if (s2_ff.b.side_ct == CT_NONE && found) begin
         push_job.arith = (s2_ff.sq[sel] != '0);
         case (sel)
            2'd0:    push_job.contact = CT_TL;
            2'd1:    push_job.contact = CT_TR;
            2'd2:    push_job.contact = CT_BL;
            default: push_job.contact = CT_BR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
      end
      if (adv) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
   end

endmodule

// ===== design/cscr_queue.sv =====
// Short job queue between the front end and the back end.
module cscr_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  cscr_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output cscr_pkg::job_type head_job
);
   import cscr_pkg::*;

   job_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ff, rd_ff;
   logic [QPTR_W:0]     cnt_ff;
   logic                do_pop;

   assign full       = (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_job   = mem_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push_valid) wr_ff <= wr_ff + 1'b1;
         if (do_pop) rd_ff <= rd_ff + 1'b1;
         if (push_valid && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (!push_valid && do_pop) cnt_ff <= cnt_ff - 1'b1;
      end
      if (push_valid) mem_ff[wr_ff] <= push_job;
   end

   assert property (@(posedge clock) disable iff (reset) full |-> !push_valid)
      else $error("queue push while full");

endmodule

// ===== design/cscr_back.sv =====
// Back end: square root, normal division, reflection and output register.
module cscr_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               job_valid,
   input  cscr_pkg::job_type                  job,
   output logic                               job_pop,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic                               rsp_hit,
   output logic [3:0]                         rsp_contact,
   output logic signed [cscr_pkg::POS_W-1:0]  rsp_new_x,
   output logic signed [cscr_pkg::POS_W-1:0]  rsp_new_y,
   output logic signed [cscr_pkg::HEAD_W-1:0] rsp_new_heading_x,
   output logic signed [cscr_pkg::HEAD_W-1:0] rsp_new_heading_y
);
   import cscr_pkg::*;

   localparam int RT_W  = 2*SQ_STAGES + 1;
   localparam int NUM_W = 48;
   localparam int S_W   = SQ_STAGES + 1;
   localparam int PP_W  = HEAD_W + RAD_W + 2;
   localparam int DOT_W = 2*HEAD_W + 1;
   localparam int G_W   = DOT_W + HEAD_W + 1;

   function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v, input int k);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      q   = (mag + (64'd1 << (k - 1))) >> k;
      rnd_shr = (v < 0) ? -$signed(q) : $signed(q);
   endfunction

   logic adv;

   job_type          sq_job_ff [SQ_STAGES+1];
   logic [SQ_STAGES:0] sq_v_ff;
   logic [RT_W-1:0]  sq_rem_ff [SQ_STAGES+1];
   logic [RT_W-1:0]  sq_res_ff [SQ_STAGES+1];
   logic [RT_W-1:0]  sq_rem_in [SQ_STAGES+1];
   logic [RT_W-1:0]  sq_res_in [SQ_STAGES+1];

   job_type          dv_job_ff [QUO_W+1];
   logic [QUO_W:0]   dv_v_ff;
   logic [S_W-1:0]   dv_s_ff   [QUO_W+1];
   logic [NUM_W-1:0] dv_rx_ff  [QUO_W+1];
   logic [NUM_W-1:0] dv_ry_ff  [QUO_W+1];
   logic [QUO_W-1:0] dv_qx_ff  [QUO_W+1];
   logic [QUO_W-1:0] dv_qy_ff  [QUO_W+1];
   logic [NUM_W-1:0] dv_rx_in  [QUO_W+1];
   logic [NUM_W-1:0] dv_ry_in  [QUO_W+1];
   logic [QUO_W-1:0] dv_qx_in  [QUO_W+1];
   logic [QUO_W-1:0] dv_qy_in  [QUO_W+1];

   job_type                  m1_job_ff, m2_job_ff, m3_job_ff;
   logic                     m1_v_ff, m2_v_ff, m3_v_ff;
   logic signed [HEAD_W-1:0] m1_nx_in, m1_ny_in, m1_nx_ff, m1_ny_ff, m2_nx_ff, m2_ny_ff;
   logic signed [31:0]       m1_hpx_ff, m1_hpy_ff;
   logic signed [PP_W-1:0]   m1_ppx_ff, m1_ppy_ff;
   logic signed [DOT_W-1:0]  m2_dot_ff;
   logic signed [POS_W-1:0]  m2_opx_ff, m2_opy_ff, m3_opx_ff, m3_opy_ff;
   logic signed [G_W-1:0]    m3_gx_ff, m3_gy_ff;

   logic                     out_v_ff, out_hit_ff;
   logic [3:0]               out_ct_ff;
   logic signed [POS_W-1:0]  out_x_ff, out_y_ff, out_x_in, out_y_in;
   logic signed [HEAD_W-1:0] out_hx_ff, out_hy_ff, out_hx_in, out_hy_in;

   assign adv     = !out_v_ff || rsp_ready;
   assign job_pop = adv;

   always_comb begin
      logic [RT_W-1:0] bitv;
      logic [RT_W-1:0] trial;
      sq_rem_in[0] = RT_W'(job.d2) << NORM_BITS;
      sq_res_in[0] = '0;
      for (int i = 0; i < SQ_STAGES; i++) begin
         bitv  = RT_W'(1) << (2*(SQ_STAGES - 1 - i));
         trial = sq_res_ff[i] + bitv;
         if (sq_rem_ff[i] >= trial) begin
            sq_rem_in[i+1] = sq_rem_ff[i] - trial;
            sq_res_in[i+1] = (sq_res_ff[i] >> 1) + bitv;
         end else begin
            sq_rem_in[i+1] = sq_rem_ff[i];
            sq_res_in[i+1] = sq_res_ff[i] >> 1;
         end
      end
   end

   always_comb begin
      logic [DLT_W-1:0] ax, ay;
      logic [S_W-1:0]   s0;
      logic [NUM_W-1:0] dsh;
      s0 = sq_res_ff[SQ_STAGES][S_W-1:0];
      ax = sq_job_ff[SQ_STAGES].dx[DLT_W-1] ? DLT_W'(-sq_job_ff[SQ_STAGES].dx)
                                            : sq_job_ff[SQ_STAGES].dx;
      ay = sq_job_ff[SQ_STAGES].dy[DLT_W-1] ? DLT_W'(-sq_job_ff[SQ_STAGES].dy)
                                            : sq_job_ff[SQ_STAGES].dy;
      dv_rx_in[0] = (NUM_W'(ax) << NORM_BITS) + NUM_W'(s0 >> 1);
      dv_ry_in[0] = (NUM_W'(ay) << NORM_BITS) + NUM_W'(s0 >> 1);
      dv_qx_in[0] = '0;
      dv_qy_in[0] = '0;
      for (int j = 0; j < QUO_W; j++) begin
         dsh = NUM_W'(dv_s_ff[j]) << (QUO_W - 1 - j);
         dv_rx_in[j+1] = dv_rx_ff[j];
         dv_qx_in[j+1] = dv_qx_ff[j];
         dv_ry_in[j+1] = dv_ry_ff[j];
         dv_qy_in[j+1] = dv_qy_ff[j];
         if (dv_rx_ff[j] >= dsh) begin
            dv_rx_in[j+1] = dv_rx_ff[j] - dsh;
            dv_qx_in[j+1] = dv_qx_ff[j] | (QUO_W'(1) << (QUO_W - 1 - j));
         end
         if (dv_ry_ff[j] >= dsh) begin
            dv_ry_in[j+1] = dv_ry_ff[j] - dsh;
            dv_qy_in[j+1] = dv_qy_ff[j] | (QUO_W'(1) << (QUO_W - 1 - j));
         end
      end
   end

   always_comb begin
      logic [QUO_W-1:0] qx, qy;
      qx = dv_qx_ff[QUO_W];
      qy = dv_qy_ff[QUO_W];
      if (qx > QUO_W'(2**UNIT_BITS)) qx = QUO_W'(2**UNIT_BITS);
      if (qy > QUO_W'(2**UNIT_BITS)) qy = QUO_W'(2**UNIT_BITS);
      m1_nx_in = dv_job_ff[QUO_W].dx[DLT_W-1] ? -$signed(HEAD_W'(qx)) : $signed(HEAD_W'(qx));
      m1_ny_in = dv_job_ff[QUO_W].dy[DLT_W-1] ? -$signed(HEAD_W'(qy)) : $signed(HEAD_W'(qy));
   end

   always_comb begin
      out_x_in  = m3_job_ff.px;
      out_y_in  = m3_job_ff.py;
      out_hx_in = m3_job_ff.phx;
      out_hy_in = m3_job_ff.phy;
      if (m3_job_ff.arith) begin
         out_x_in  = m3_opx_ff;
         out_y_in  = m3_opy_ff;
         out_hx_in = sat_head(32'(m3_job_ff.hx) - 32'(rnd_shr(64'(m3_gx_ff), NORM_BITS)));
         out_hy_in = sat_head(32'(m3_job_ff.hy) - 32'(rnd_shr(64'(m3_gy_ff), NORM_BITS)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff  <= '0;
         dv_v_ff  <= '0;
         m1_v_ff  <= 1'b0;
         m2_v_ff  <= 1'b0;
         m3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         sq_v_ff  <= {sq_v_ff[SQ_STAGES-1:0], job_valid};
         dv_v_ff  <= {dv_v_ff[QUO_W-1:0], sq_v_ff[SQ_STAGES]};
         m1_v_ff  <= dv_v_ff[QUO_W];
         m2_v_ff  <= m1_v_ff;
         m3_v_ff  <= m2_v_ff;
         out_v_ff <= m3_v_ff;
      end
      if (adv) begin
         sq_job_ff[0] <= job;
         for (int i = 0; i <= SQ_STAGES; i++) begin
            if (i > 0) sq_job_ff[i] <= sq_job_ff[i-1];
            sq_rem_ff[i] <= sq_rem_in[i];
            sq_res_ff[i] <= sq_res_in[i];
         end
         dv_job_ff[0] <= sq_job_ff[SQ_STAGES];
         dv_s_ff[0]   <= sq_res_ff[SQ_STAGES][S_W-1:0];
         for (int j = 0; j <= QUO_W; j++) begin
            if (j > 0) begin
               dv_job_ff[j] <= dv_job_ff[j-1];
               dv_s_ff[j]   <= dv_s_ff[j-1];
            end
            dv_rx_ff[j] <= dv_rx_in[j];
            dv_ry_ff[j] <= dv_ry_in[j];
            dv_qx_ff[j] <= dv_qx_in[j];
            dv_qy_ff[j] <= dv_qy_in[j];
         end
         m1_job_ff <= dv_job_ff[QUO_W];
         m1_nx_ff  <= m1_nx_in;
         m1_ny_ff  <= m1_ny_in;
         m1_hpx_ff <= 32'(dv_job_ff[QUO_W].hx) * 32'(m1_nx_in);
         m1_hpy_ff <= 32'(dv_job_ff[QUO_W].hy) * 32'(m1_ny_in);
         m1_ppx_ff <= PP_W'(m1_nx_in) * $signed(PP_W'({1'b0, dv_job_ff[QUO_W].r}));
         m1_ppy_ff <= PP_W'(m1_ny_in) * $signed(PP_W'({1'b0, dv_job_ff[QUO_W].r}));
         m2_job_ff <= m1_job_ff;
         m2_nx_ff  <= m1_nx_ff;
         m2_ny_ff  <= m1_ny_ff;
         m2_dot_ff <= DOT_W'(m1_hpx_ff) + DOT_W'(m1_hpy_ff);
         m2_opx_ff <= sat_pos(32'(m1_job_ff.cx) + 32'(rnd_shr(64'(m1_ppx_ff), UNIT_BITS)));
         m2_opy_ff <= sat_pos(32'(m1_job_ff.cy) + 32'(rnd_shr(64'(m1_ppy_ff), UNIT_BITS)));
         m3_job_ff <= m2_job_ff;
         m3_opx_ff <= m2_opx_ff;
         m3_opy_ff <= m2_opy_ff;
         m3_gx_ff  <= (G_W'(m2_dot_ff) * G_W'(m2_nx_ff)) <<< 1;
         m3_gy_ff  <= (G_W'(m2_dot_ff) * G_W'(m2_ny_ff)) <<< 1;
         out_hit_ff <= (m3_job_ff.contact != CT_NONE);
         out_ct_ff  <= m3_job_ff.contact;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         out_hx_ff  <= out_hx_in;
         out_hy_ff  <= out_hy_in;
      end
   end

   assign rsp_valid         = out_v_ff;
   assign rsp_hit           = out_hit_ff;
   assign rsp_contact       = out_ct_ff;
   assign rsp_new_x         = out_x_ff;
   assign rsp_new_y         = out_y_ff;
   assign rsp_new_heading_x = out_hx_ff;
   assign rsp_new_heading_y = out_hy_ff;

endmodule

// ===== design/circle_square_collision_response_top.sv =====
// Circle versus square collision response, top level.
//
// Request channel (req_): one beat carries a circle centre, its heading and
// the square's top-left corner. Response channel (rsp_): one beat per
// request, in order, with the contact code, corrected centre and heading.
// Config channel (csr_): index 0 writes the circle radius, index 1 the
// square side; other indexes are dropped. Write only while the block is idle.
// One request is taken every cycle unless the receiver stalls; the rate is
// set by the fully pipelined back end (a 30-stage square root and a 17-stage
// divider per normal component).
// The front end and back end are joined by a 4-entry queue, so a stalled
// receiver halts the back end pipeline while the front end keeps filling
// the queue; once it is full and the front end holds a job, req_ready drops.
// Reset empties all pipelines and the queue and restores radius 1280 and
// side 12800.
module circle_square_collision_response_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [cscr_pkg::POS_W-1:0]  req_circle_x,
   input  logic signed [cscr_pkg::POS_W-1:0]  req_circle_y,
   input  logic signed [cscr_pkg::HEAD_W-1:0] req_heading_x,
   input  logic signed [cscr_pkg::HEAD_W-1:0] req_heading_y,
   input  logic signed [cscr_pkg::POS_W-1:0]  req_square_left,
   input  logic signed [cscr_pkg::POS_W-1:0]  req_square_top,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_hit,
   output logic [3:0]                         rsp_contact,
   output logic signed [cscr_pkg::POS_W-1:0]  rsp_new_x,
   output logic signed [cscr_pkg::POS_W-1:0]  rsp_new_y,
   output logic signed [cscr_pkg::HEAD_W-1:0] rsp_new_heading_x,
   output logic signed [cscr_pkg::HEAD_W-1:0] rsp_new_heading_y,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [cscr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cscr_pkg::SIDE_W-1:0]        csr_data
);
   import cscr_pkg::*;

   logic [RAD_W-1:0]  radius_ff;
   logic [SIDE_W-1:0] side_ff;
   logic              push_valid, q_full, q_valid, q_pop;
   job_type           push_job, q_job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= RAD_W'(1280);
         side_ff   <= SIDE_W'(12800);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RADIUS: radius_ff <= csr_data[RAD_W-1:0];
            CSR_SIDE:   side_ff   <= csr_data;
            default:    ;
         endcase
      end
   end

   cscr_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_circle_x   (req_circle_x),
      .req_circle_y   (req_circle_y),
      .req_heading_x  (req_heading_x),
      .req_heading_y  (req_heading_y),
      .req_square_left(req_square_left),
      .req_square_top (req_square_top),
      .cfg_radius     (radius_ff),
      .cfg_side       (side_ff),
      .push_valid     (push_valid),
      .push_job       (push_job),
      .push_full      (q_full)
   );

   cscr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_job  (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .head_valid(q_valid),
      .head_job  (q_job)
   );

   cscr_back u_back (
      .clock            (clock),
      .reset            (reset),
      .job_valid        (q_valid),
      .job              (q_job),
      .job_pop          (q_pop),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_contact      (rsp_contact),
      .rsp_new_x        (rsp_new_x),
      .rsp_new_y        (rsp_new_y),
      .rsp_new_heading_x(rsp_new_heading_x),
      .rsp_new_heading_y(rsp_new_heading_y)
   );

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_hit == (rsp_contact != CT_NONE)))
      else $error("hit flag disagrees with contact code");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_contact <= CT_BR))
      else $error("contact code out of range");

   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

endmodule

// ===== tb/tb.sv =====
// Testbench for circle_square_collision_response_top: directed table, then randomized probes.
`timescale 1ns / 1ps

module tb;
   import cscr_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 70;
   localparam int ITEMS_PER_SET  = 24;
   localparam int HOLD_ITEMS     = 96;

   typedef struct {
      logic signed [POS_W-1:0]  cx;
      logic signed [POS_W-1:0]  cy;
      logic signed [HEAD_W-1:0] hx;
      logic signed [HEAD_W-1:0] hy;
      logic signed [POS_W-1:0]  sl;
      logic signed [POS_W-1:0]  st;
   } probe_type;

   typedef struct {
      logic                     hit;
      contact_type              contact;
      logic signed [POS_W-1:0]  nx;
      logic signed [POS_W-1:0]  ny;
      logic signed [HEAD_W-1:0] nhx;
      logic signed [HEAD_W-1:0] nhy;
   } bounce_type;

   typedef struct {
      probe_type  p;
      bit         typed;
      bounce_type want;
   } row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic signed [POS_W-1:0]  req_circle_x = '0;
   logic signed [POS_W-1:0]  req_circle_y = '0;
   logic signed [HEAD_W-1:0] req_heading_x = '0;
   logic signed [HEAD_W-1:0] req_heading_y = '0;
   logic signed [POS_W-1:0]  req_square_left = '0;
   logic signed [POS_W-1:0]  req_square_top = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_hit;
   logic [3:0]               rsp_contact;
   logic signed [POS_W-1:0]  rsp_new_x;
   logic signed [POS_W-1:0]  rsp_new_y;
   logic signed [HEAD_W-1:0] rsp_new_heading_x;
   logic signed [HEAD_W-1:0] rsp_new_heading_y;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [SIDE_W-1:0]        csr_data = '0;

   bit         row_typed = 1'b0;
   bounce_type row_want;
   bit         hold_on = 1'b0;
   int         hold_cnt = 0;
   int         snd_idle = 0;
   int         rcv_idle = 0;
   longint     radius_mirror = 1280;
   longint     side_mirror = 12800;
   bounce_type bounce_q[$];
   int         errors = 0;
   int         quiet_cycles = 0;

   circle_square_collision_response_top dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clip(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint root_floor(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(res);
   endfunction

   function automatic longint div_round(longint num, longint den);
      longint mag, q;
      mag = num < 0 ? -num : num;
      q = (mag + den / 2) / den;
      return num < 0 ? -q : q;
   endfunction

   function automatic longint unit_clamp(longint v);
      return v > 16384 ? 16384 : (v < -16384 ? -16384 : v);
   endfunction

   function automatic bounce_type collide(probe_type p);
      longint x, y, hx, hy, lf, tp, r, rt, bt, px, py, phx, phy;
      longint dx, dy, d2, s, nx, ny, dot;
      longint kx[4], ky[4];
      bit ys, xs;
      contact_type c;
      bounce_type o;
      x = longint'(p.cx); y = longint'(p.cy); hx = longint'(p.hx); hy = longint'(p.hy);
      lf = longint'(p.sl); tp = longint'(p.st);
      r = radius_mirror;
      rt = lf + side_mirror;
      bt = tp + side_mirror;
      px = x; py = y; phx = hx; phy = hy;
      c = CT_NONE;
      ys = (y + r >= tp) && (y - r <= bt);
      xs = (x + r >= lf) && (x - r <= rt);
      if (x + r >= lf && x < lf && ys) begin
         c = CT_LEFT; px = lf - r; phx = -hx;
      end else if (x - r <= rt && x > rt && ys) begin
         c = CT_RIGHT; px = rt + r; phx = -hx;
      end else if (y + r >= tp && y < tp && xs) begin
         c = CT_TOP; py = tp - r; phy = -hy;
      end else if (y - r <= bt && y > bt && xs) begin
         c = CT_BOTTOM; py = bt + r; phy = -hy;
      end else begin
         kx[0] = lf; ky[0] = tp;
         kx[1] = rt; ky[1] = tp;
         kx[2] = lf; ky[2] = bt;
         kx[3] = rt; ky[3] = bt;
         for (int k = 0; k < 4; k++) begin
            dx = x - kx[k];
            dy = y - ky[k];
            d2 = dx * dx + dy * dy;
            if (d2 <= r * r) begin
               c = contact_type'(5 + k);
               if (d2 != 0) begin
                  s = root_floor(longint'(d2) << 28);
                  nx = unit_clamp(div_round(dx <<< 28, s));
                  ny = unit_clamp(div_round(dy <<< 28, s));
                  dot = hx * nx + hy * ny;
                  phx = hx - div_round(2 * dot * nx, longint'(1) << 28);
                  phy = hy - div_round(2 * dot * ny, longint'(1) << 28);
                  px = kx[k] + div_round(nx * r, longint'(1) << 14);
                  py = ky[k] + div_round(ny * r, longint'(1) << 14);
               end
               break;
            end
         end
      end
      o.hit = (c != CT_NONE);
      o.contact = c;
      o.nx = POS_W'(clip(px, POS_W));
      o.ny = POS_W'(clip(py, POS_W));
      o.nhx = HEAD_W'(clip(phx, HEAD_W));
      o.nhy = HEAD_W'(clip(phy, HEAD_W));
      return o;
   endfunction

   // receiver: long hold-off on request, otherwise random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_on && hold_cnt < HOLD_CYCLES) begin
         rsp_ready <= 1'b0;
         hold_cnt <= hold_cnt + 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_idle);
      end
   end

   always @(posedge clock) begin
      bounce_type e;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_RADIUS: radius_mirror = longint'(csr_data[RAD_W-1:0]);
               CSR_SIDE:   side_mirror = longint'(csr_data);
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (row_typed) begin
               bounce_q.push_back(row_want);
            end else begin
               bounce_q.push_back(collide('{req_circle_x, req_circle_y, req_heading_x,
                                            req_heading_y, req_square_left, req_square_top}));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (bounce_q.size() == 0) begin
               $display("%0t: unexpected beat contact %0d", $time, rsp_contact);
               errors++;
            end else begin
               e = bounce_q.pop_front();
               if (rsp_hit !== e.hit || rsp_contact !== 4'(e.contact) ||
                   rsp_new_x !== e.nx || rsp_new_y !== e.ny ||
                   rsp_new_heading_x !== e.nhx || rsp_new_heading_y !== e.nhy) begin
                  $display("%0t: expected hit %0d contact %0d x %0d y %0d hx %0d hy %0d",
                           $time, e.hit, e.contact, e.nx, e.ny, e.nhx, e.nhy);
                  $display("%0t:   actual hit %0d contact %0d x %0d y %0d hx %0d hy %0d",
                           $time, rsp_hit, rsp_contact, rsp_new_x, rsp_new_y,
                           rsp_new_heading_x, rsp_new_heading_y);
                  errors++;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL circle_square_collision_response_top");
            $finish;
         end
      end
   end

   task automatic send(probe_type p, bit typed, bounce_type want);
      bit ok;
      while ($urandom_range(99) < snd_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_circle_x <= p.cx;
      req_circle_y <= p.cy;
      req_heading_x <= p.hx;
      req_heading_y <= p.hy;
      req_square_left <= p.sl;
      req_square_top <= p.st;
      row_typed <= typed;
      row_want <= want;
      do begin
         @(negedge clock);
         ok = req_ready;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (bounce_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [SIDE_W-1:0] val);
      bit ok;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do begin
         @(negedge clock);
         ok = csr_ready;
         @(posedge clock);
      end while (!ok);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic probe_type random_probe();
      probe_type p;
      longint r, s, span;
      p.hx = HEAD_W'($urandom);
      p.hy = HEAD_W'($urandom);
      if ($urandom_range(99) < 25) begin
         p.cx = POS_W'($urandom); p.cy = POS_W'($urandom);
         p.sl = POS_W'($urandom); p.st = POS_W'($urandom);
      end else begin
         r = radius_mirror;
         s = side_mirror;
         p.sl = POS_W'(longint'($urandom_range(400000)) - 200000);
         p.st = POS_W'(longint'($urandom_range(400000)) - 200000);
         span = s + 2 * r + 400;
         p.cx = POS_W'(longint'(p.sl) + longint'($urandom_range(int'(span))) - (r + 200));
         p.cy = POS_W'(longint'(p.st) + longint'($urandom_range(int'(span))) - (r + 200));
      end
      return p;
   endfunction

   initial begin
      row_type rows[$];
      bounce_type none;
      longint settings[6][2];
      none = '{1'b0, CT_NONE, '0, '0, '0, '0};
      settings = '{'{1280, 12800}, '{0, 0}, '{65535, 262143}, '{300, 2000},
                   '{65535, 0}, '{0, 262143}};
      rows = '{
         '{'{0, 0, 1000, -2000, 100000, 100000}, 1, '{0, CT_NONE, 0, 0, 1000, -2000}},
         '{'{-512, 6400, 16384, 0, 0, 0}, 1, '{1, CT_LEFT, -1280, 6400, -16384, 0}},
         '{'{13312, 6400, 16384, 5, 0, 0}, 1, '{1, CT_RIGHT, 14080, 6400, -16384, 5}},
         '{'{6400, -512, 0, -32768, 0, 0}, 1, '{1, CT_TOP, 6400, -1280, 0, 32767}},
         '{'{6400, 13312, 3, 32767, 0, 0}, 1, '{1, CT_BOTTOM, 6400, 14080, 3, -32767}},
         '{'{0, 0, 100, 200, 0, 0}, 1, '{1, CT_TL, 0, 0, 100, 200}},
         '{'{12800, 0, -7, 9, 0, 0}, 1, '{1, CT_TR, 12800, 0, -7, 9}},
         '{'{0, 12800, 11, 12, 0, 0}, 1, '{1, CT_BL, 0, 12800, 11, 12}},
         '{'{12800, 12800, 13, 14, 0, 0}, 1, '{1, CT_BR, 12800, 12800, 13, 14}},
         '{'{-1048576, 6400, -32768, 1, -1048476, 0}, 1,
           '{1, CT_LEFT, -1048576, 6400, 32767, 1}},
         '{'{6400, 6400, 32767, -32768, 0, 0}, 1, '{0, CT_NONE, 6400, 6400, 32767, -32768}},
         '{'{100, 50, 16384, 16384, 0, 0}, 0, none},
         '{'{12700, 30, -32768, 32767, 0, 0}, 0, none},
         '{'{40, 12760, 32767, -32768, 0, 0}, 0, none},
         '{'{12790, 12790, -32768, -32768, 0, 0}, 0, none},
         '{'{1048575, 1048575, 32767, 32767, 1048575, 1048575}, 0, none},
         '{'{-1048576, -1048576, -32768, -32768, -1048576, -1048576}, 0, none},
         '{'{1048575, 0, 5, 5, 1048575 - 12800, 0}, 0, none},
         '{'{600, 600, -16384, 0, 0, 0}, 0, none}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      snd_idle = 18;
      rcv_idle = 70;
      foreach (rows[i]) send(rows[i].p, rows[i].typed, rows[i].want);
      drain();
      for (int mode = 0; mode < 3; mode++) begin
         snd_idle = mode == 0 ? 18 : (mode == 1 ? 70 : 0);
         rcv_idle = mode == 0 ? 70 : (mode == 1 ? 18 : 0);
         for (int k = 0; k < 6; k++) begin
            write_reg(CSR_RADIUS, SIDE_W'(settings[(k + mode) % 6][0]));
            write_reg(CSR_SIDE, SIDE_W'(settings[(k + mode) % 6][1]));
            if (k == 2) begin
               write_reg(csr_index_type'(2), SIDE_W'($urandom));
               write_reg(csr_index_type'(3), SIDE_W'($urandom));
               write_reg(CSR_RADIUS, SIDE_W'($urandom));
            end
            if (mode == 2 && k == 1) hold_on <= 1'b1;
            repeat ((mode == 2 && k == 1) ? HOLD_ITEMS : ITEMS_PER_SET)
               send(random_probe(), 1'b0, none);
            drain();
            hold_on <= 1'b0;
         end
      end
      drain();
      if (errors == 0)
         $display("PASS circle_square_collision_response_top");
      else
         $display("FAIL circle_square_collision_response_top");
      $finish;
   end

endmodule
